### hw/rtl/keyed_fifo_handle_pool_assert.svh
// assertion macros for the keyed handle pool
// used by keyed_fifo_handle_pool.sv, expects clk and rst in scope
`ifndef KEYED_FIFO_HANDLE_POOL_ASSERT_SVH
`define KEYED_FIFO_HANDLE_POOL_ASSERT_SVH
`ifndef SYNTH
`define KFHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KFHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KFHP_ASSERT(lbl, prop, msg)
`define KFHP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/kfhp_pkg.sv
// shared types, constants and helpers of the keyed handle pool
// no dependencies
package kfhp_pkg;

  localparam int CAPACITY    = 256;
  localparam int HANDLE_BITS = 32;
  localparam int ENTRY_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
  localparam int KEY_SLOTS   = 20736;
  localparam int KEY_BITS    = $clog2(KEY_SLOTS);

  localparam logic [2:0] FORMAT_MAX  = 3'd5;
  localparam logic [3:0] CLASS_MAX   = 4'd11;
  localparam logic       DYNAMIC_MAX = 1'b1;
  localparam logic [KEY_BITS-1:0] FORMAT_COUNT = KEY_BITS'(6);
  localparam logic [KEY_BITS-1:0] CLASS_COUNT  = KEY_BITS'(12);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_TAKE   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                  in_range;
    logic [KEY_BITS-1:0]   key;
  } key_info_t;

  typedef struct packed {
    logic                  busy;
    logic [ENTRY_BITS-1:0] first;
    logic [ENTRY_BITS-1:0] last;
  } hdr_t;

  localparam int HDR_BITS = $bits(hdr_t);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_START,
    S_WALK_RD,
    S_WALK_RING,
    S_WALK_HDR,
    S_TAKE,
    S_POP,
    S_POST,
    S_INS,
    S_INS_WR,
    S_FINISH
  } state_t;

  function automatic logic [ENTRY_BITS-1:0] pos_inc(input logic [ENTRY_BITS-1:0] p);
    logic [ENTRY_BITS-1:0] r;
    if (p == ENTRY_BITS'(CAPACITY - 1)) r = '0;
    else r = p + ENTRY_BITS'(1);
    return r;
  endfunction

endpackage

### hw/rtl/kfhp_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module kfhp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

### hw/rtl/kfhp_key_check.sv
// range check and slot index of the five key parts
// depends on kfhp_pkg
module kfhp_key_check (
  input  logic                dynamic_flag,
  input  logic [2:0]          pixel_format,
  input  logic [3:0]          width_class,
  input  logic [3:0]          height_class,
  input  logic [3:0]          mip_class,
  output kfhp_pkg::key_info_t info
);
  import kfhp_pkg::*;

  logic [KEY_BITS-1:0] k;

  always_comb begin
    info.in_range = (dynamic_flag <= DYNAMIC_MAX) && (pixel_format <= FORMAT_MAX) &&
                    (width_class <= CLASS_MAX) && (height_class <= CLASS_MAX) &&
                    (mip_class <= CLASS_MAX);
    k = KEY_BITS'(dynamic_flag) * FORMAT_COUNT + KEY_BITS'(pixel_format);
    k = k * CLASS_COUNT + KEY_BITS'(width_class);
    k = k * CLASS_COUNT + KEY_BITS'(height_class);
    k = k * CLASS_COUNT + KEY_BITS'(mip_class);
    info.key = info.in_range ? k : '0;
  end
endmodule

### hw/rtl/keyed_fifo_handle_pool.sv
// Keyed handle pool: up to CAPACITY handles kept in one fifo queue per key
// (20736 key slots). Slot headers, entry handles, entry links, the free
// stack and the insert ring each live in a synchronous ram; a sequencer
// does the header updates as read, modify, write back. One item at a time:
// a take reads the slot header and head entry, then writes the header back;
// an insert on a full pool first walks the insert ring (at most CAPACITY
// entries) and evicts the head of the first busy slot; a clear runs a
// clearing pass over all 20736 slot headers. The same pass follows reset,
// during which no item is accepted. A result held in the output register
// does not block acceptance of the next item, only its S_FINISH step.
// depends on kfhp_pkg, kfhp_ram, kfhp_key_check, keyed_fifo_handle_pool_assert.svh
`include "keyed_fifo_handle_pool_assert.svh"
module keyed_fifo_handle_pool (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic        dynamic_flag,
  input  logic [2:0]  pixel_format,
  input  logic [3:0]  width_class,
  input  logic [3:0]  height_class,
  input  logic [3:0]  mip_class,
  input  logic [31:0] handle_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] handle_out,
  output logic        evicted,
  output logic [31:0] evicted_handle
);
  import kfhp_pkg::*;

  state_t state, state_next;

  // latched item
  logic [1:0]             op_q;
  logic [KEY_BITS-1:0]    key_q;
  logic                   inr_q;
  logic [HANDLE_BITS-1:0] hin_q;
  key_info_t              key_info;

  // control state
  logic [ENTRY_BITS-1:0]  pos;
  logic [COUNT_BITS-1:0]  count;
  logic [COUNT_BITS-1:0]  walk_n;
  logic                   room;
  logic                   from_walk;
  logic [KEY_BITS-1:0]    pop_key;
  logic [KEY_BITS-1:0]    sweep;
  logic                   sweep_report;
  logic [ENTRY_BITS-1:0]  free_a_q;
  logic [CAPACITY-1:0]    fvalid;   // free stack entry written since reset or clear
  logic [CAPACITY-1:0]    rwritten; // ring entry ever written

  // popped slot header, kept across the entry read
  hdr_t                   hdr_q;
  hdr_t                   hdr_q_pop;

  // result being built
  logic [1:0]             res_status;
  logic [HANDLE_BITS-1:0] res_hout;
  logic                   res_ev;
  logic [HANDLE_BITS-1:0] res_evh;

  // ram ports
  logic                   hdr_we, hdr_re;
  logic [KEY_BITS-1:0]    hdr_wa, hdr_ra;
  hdr_t                   hdr_wd, hdr_rd;
  logic                   hnd_we, lnk_we, ent_re;
  logic [ENTRY_BITS-1:0]  hnd_wa, lnk_wa, lnk_wd, ent_ra, lnk_rd;
  logic [HANDLE_BITS-1:0] hnd_rd;
  logic                   free_we, free_re;
  logic [ENTRY_BITS-1:0]  free_wa, free_wd, free_ra, free_rd;
  logic                   ring_we, ring_re;
  logic [KEY_BITS-1:0]    ring_rd;

  logic                   accept;
  logic [ENTRY_BITS-1:0]  new_e;
  logic                   walk_last;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign new_e     = fvalid[free_a_q] ? free_rd : free_a_q;
  assign walk_last = (walk_n == COUNT_BITS'(CAPACITY - 1));

  kfhp_key_check u_key (
    .dynamic_flag (dynamic_flag),
    .pixel_format (pixel_format),
    .width_class  (width_class),
    .height_class (height_class),
    .mip_class    (mip_class),
    .info         (key_info)
  );

  kfhp_ram #(.WIDTH(HDR_BITS), .DEPTH(KEY_SLOTS)) u_hdr_ram (
    .clk(clk), .wr_en(hdr_we), .wr_addr(hdr_wa), .wr_data(hdr_wd),
    .rd_en(hdr_re), .rd_addr(hdr_ra), .rd_data(hdr_rd)
  );

  kfhp_ram #(.WIDTH(HANDLE_BITS), .DEPTH(CAPACITY)) u_hnd_ram (
    .clk(clk), .wr_en(hnd_we), .wr_addr(hnd_wa), .wr_data(hin_q),
    .rd_en(ent_re), .rd_addr(ent_ra), .rd_data(hnd_rd)
  );

  kfhp_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CAPACITY)) u_lnk_ram (
    .clk(clk), .wr_en(lnk_we), .wr_addr(lnk_wa), .wr_data(lnk_wd),
    .rd_en(ent_re), .rd_addr(ent_ra), .rd_data(lnk_rd)
  );

  kfhp_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
    .rd_en(free_re), .rd_addr(free_ra), .rd_data(free_rd)
  );

  kfhp_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_ring_ram (
    .clk(clk), .wr_en(ring_we), .wr_addr(pos), .wr_data(key_q),
    .rd_en(ring_re), .rd_addr(pos), .rd_data(ring_rd)
  );

  // sequencer: next state and ram strobes
  always_comb begin
    state_next = state;
    hdr_we  = 1'b0; hdr_wa = key_q; hdr_wd = hdr_rd;
    hdr_re  = 1'b0; hdr_ra = key_q;
    hnd_we  = 1'b0; hnd_wa = new_e;
    lnk_we  = 1'b0; lnk_wa = hdr_rd.last; lnk_wd = new_e;
    ent_re  = 1'b0; ent_ra = hdr_rd.first;
    free_we = 1'b0; free_wa = ENTRY_BITS'(CAPACITY - int'(count)); free_wd = hdr_rd.first;
    free_re = 1'b0; free_ra = ENTRY_BITS'(CAPACITY - 1 - int'(count));
    ring_we = 1'b0; ring_re = 1'b0;
    case (state)
      S_SWEEP: begin
        hdr_we = 1'b1;
        hdr_wa = sweep;
        hdr_wd = '0;
        if (sweep == KEY_BITS'(KEY_SLOTS - 1)) begin
          state_next = sweep_report ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) state_next = S_START;
      end
      S_START: begin
        case (op_q)
          OP_INSERT: begin
            state_next = (count >= COUNT_BITS'(CAPACITY)) ? S_WALK_RD : S_POST;
          end
          OP_TAKE: begin
            if (inr_q) begin
              hdr_re = 1'b1;
              state_next = S_TAKE;
            end else begin
              state_next = S_FINISH;
            end
          end
          OP_CLEAR: state_next = S_SWEEP;
          default:  state_next = S_FINISH;
        endcase
      end
      S_WALK_RD: begin
        ring_re = 1'b1;
        state_next = S_WALK_RING;
      end
      S_WALK_RING: begin
        if (rwritten[pos]) begin
          hdr_re = 1'b1;
          hdr_ra = ring_rd;
          state_next = S_WALK_HDR;
        end else begin
          state_next = walk_last ? S_POST : S_WALK_RD;
        end
      end
      S_WALK_HDR: begin
        if (hdr_rd.busy) begin
          ent_re = 1'b1;
          state_next = S_POP;
        end else begin
          state_next = walk_last ? S_POST : S_WALK_RD;
        end
      end
      S_TAKE: begin
        if (hdr_rd.busy) begin
          ent_re = 1'b1;
          state_next = S_POP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_POP: begin
        // header register still holds the popped slot
        hdr_we = 1'b1;
        hdr_wa = pop_key;
        hdr_wd = hdr_q_pop;
        free_we = (count != '0);
        free_wd = hdr_q.first;
        state_next = from_walk ? S_POST : S_FINISH;
      end
      S_POST: begin
        if (inr_q && room) state_next = S_INS;
        else state_next = S_FINISH;
      end
      S_INS: begin
        free_re = 1'b1;
        hdr_re  = 1'b1;
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        hnd_we = 1'b1;
        lnk_we = hdr_rd.busy;
        hdr_we = 1'b1;
        hdr_wd.busy  = 1'b1;
        hdr_wd.first = hdr_rd.busy ? hdr_rd.first : new_e;
        hdr_wd.last  = new_e;
        ring_we = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    hdr_q_pop = hdr_q;
    if (hdr_q.first == hdr_q.last) hdr_q_pop.busy = 1'b0;
    else hdr_q_pop.first = lnk_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep        <= '0;
      sweep_report <= 1'b0;
      count        <= '0;
      pos          <= '0;
      fvalid       <= '0;
      rwritten     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_SWEEP: begin
          sweep <= sweep + KEY_BITS'(1);
        end
        S_IDLE: begin
          if (accept) begin
            op_q  <= operation;
            key_q <= key_info.key;
            inr_q <= key_info.in_range;
            hin_q <= HANDLE_BITS'(handle_in);
          end
        end
        S_START: begin
          res_status <= STATUS_OK;
          res_hout   <= '0;
          res_ev     <= 1'b0;
          res_evh    <= '0;
          walk_n     <= '0;
          room       <= (count < COUNT_BITS'(CAPACITY));
          case (op_q)
            OP_TAKE: begin
              pop_key   <= key_q;
              from_walk <= 1'b0;
              if (!inr_q) res_status <= STATUS_RANGE;
            end
            OP_CLEAR: begin
              count        <= '0;
              fvalid       <= '0;
              sweep        <= '0;
              sweep_report <= 1'b1;
            end
            default: ;
          endcase
        end
        S_WALK_RING: begin
          pop_key   <= ring_rd;
          from_walk <= 1'b1;
          if (!rwritten[pos]) begin
            pos    <= pos_inc(pos);
            walk_n <= walk_n + COUNT_BITS'(1);
          end
        end
        S_WALK_HDR: begin
          hdr_q <= hdr_rd;
          if (!hdr_rd.busy) begin
            pos    <= pos_inc(pos);
            walk_n <= walk_n + COUNT_BITS'(1);
          end
        end
        S_TAKE: begin
          hdr_q <= hdr_rd;
          if (!hdr_rd.busy) res_status <= STATUS_EMPTY;
        end
        S_POP: begin
          if (count != '0) begin
            count <= count - COUNT_BITS'(1);
            fvalid[free_wa] <= 1'b1;
          end
          if (from_walk) begin
            res_ev  <= 1'b1;
            res_evh <= hnd_rd;
            room    <= 1'b1;
          end else begin
            res_hout <= hnd_rd;
          end
        end
        S_POST: begin
          if (!inr_q) res_status <= STATUS_RANGE;
          else if (!room) res_status <= STATUS_EMPTY;
        end
        S_INS: begin
          free_a_q <= free_ra;
        end
        S_INS_WR: begin
          count         <= count + COUNT_BITS'(1);
          rwritten[pos] <= 1'b1;
          pos           <= pos_inc(pos);
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            handle_out     <= 32'(res_hout);
            evicted        <= res_ev;
            evicted_handle <= 32'(res_evh);
          end
        end
        default: ;
      endcase
      if (state != S_FINISH && out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  `KFHP_ASSERT(a_count_cap, count <= COUNT_BITS'(CAPACITY), "entry count above capacity")
  `KFHP_ASSERT(a_walk_bound, (state == S_WALK_RD) |-> (walk_n < COUNT_BITS'(CAPACITY)), "ring walk overran")
  `KFHP_ASSERT_NEXT(a_clear_empties, state == S_START && op_q == OP_CLEAR, count == '0 && fvalid == '0, "clear left entries")
  `KFHP_ASSERT(a_out_from_finish, $rose(out_valid) |-> ($past(state) == S_FINISH), "result without finish")
endmodule
